// ----- hdl/ctcgd_pkg.sv -----
// Shared widths, codes and handshake structs of the CTC greedy decoder.
`default_nettype none

package ctcgd_pkg;

  localparam int unsigned ScoreW   = 16;  // Q0.16 score
  localparam int unsigned IdxW     = 8;   // class / character index
  localparam int unsigned DictW    = 9;   // dictionary size register
  localparam int unsigned SumW     = 22;  // kept-score accumulator
  localparam int unsigned KeptW    = 7;   // kept-row counter
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDataW = 48;  // index, prob, mean, accepted, padded to bytes

  localparam logic [SumW-1:0]  SumMax  = '1;
  localparam logic [KeptW-1:0] KeptMax = '1;

  // Restoring divider: one quotient bit per cycle.
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DICT_SIZE,
    CFG_MIN_CONF
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_SUM
  } ctrl_state_e;

  typedef struct packed {
    logic accept;    // input transaction this cycle
    logic div_step;  // advance the divider one bit
    logic load_sum;  // load the summary into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic char_emit;  // current input closes a row that yields a character
    logic seq_done;   // current input closes the sequence
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/ctc_greedy_decoder.sv -----
// Top level of the CTC greedy decoder: ports, packing, controller and datapath.
//
// Usage:
//  - s_axis carries one class score per transaction (tdata = Q0.16 score),
//    row by row over time steps; tlast marks the last class of a step and
//    tuser marks, together with tlast, the last step of the sequence.
//  - m_axis carries results: tuser 0 = decoded character, 1 = end-of-sequence
//    summary (mean kept score and accepted flag); tlast is set on the summary.
//  - cfg_* writes dict_size (index 0) and min_confidence (index 1), always ready.
//    The user must write it only while no sequence is in flight (not enforced).
// Timing:
//  - One score per cycle while the output register is free or being drained.
//  - A character is valid at the output in the cycle after its row closes.
//  - A sequence end stalls the input while the bit-serial mean divider runs
//    (one quotient bit per cycle over the 22-bit sum) and until the summary
//    is loaded: ST_DIV runs the divider, then ST_SUM loads the summary once
//    the output register is free.
// Reset clears the argmax, history, accumulators, registers and valid state.
// When the receiver stalls, the single output register holds its result and
// the input is stalled while that register holds a result not yet taken.
`default_nettype none

module ctc_greedy_decoder #(
  parameter int unsigned MAX_CLASSES = 256
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // config write channel
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [ctcgd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [ctcgd_pkg::CfgDataW-1:0]     cfg_data_i,
  // score stream
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [ctcgd_pkg::ScoreW-1:0]       s_axis_tdata,   // [15:0] class_score
  input  wire                                s_axis_tlast,   // row_end
  input  wire                                s_axis_tuser,   // seq_end
  // result stream
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [ctcgd_pkg::OutDataW-1:0]     m_axis_tdata,   // [7:0] char_index,
                                                             // [23:8] char_prob,
                                                             // [39:24] mean_score,
                                                             // [40] accepted, rest 0
  output logic                               m_axis_tlast,   // last
  output logic                               m_axis_tuser    // out_kind
);
  import ctcgd_pkg::*;

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [IdxW-1:0]   out_index;
  logic [ScoreW-1:0] out_prob;
  logic [ScoreW-1:0] out_mean;
  logic              out_accepted;

  assign cfg_ready_o = 1'b1;

  ctcgd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ctcgd_dpath #(
    .MaxClasses (MAX_CLASSES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_reg_e'(cfg_index_i)),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .score_i        (s_axis_tdata),
    .row_end_i      (s_axis_tlast),
    .seq_end_i      (s_axis_tuser),
    .out_kind_o     (m_axis_tuser),
    .out_index_o    (out_index),
    .out_prob_o     (out_prob),
    .out_mean_o     (out_mean),
    .out_accepted_o (out_accepted),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = OutDataW'({out_accepted, out_mean, out_prob, out_index});

endmodule

`default_nettype wire

// ----- hdl/ctcgd_dpath.sv -----
// Datapath: row argmax, collapse/accumulate, mean divider and output register.
`default_nettype none

module ctcgd_dpath #(
  parameter int unsigned MaxClasses = 256
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     cfg_we_i,
  input  wire  ctcgd_pkg::cfg_reg_e               cfg_index_i,
  input  wire  [ctcgd_pkg::CfgDataW-1:0]          cfg_data_i,
  input  wire  ctcgd_pkg::ctrl_cmd_t              cmd_i,
  output ctcgd_pkg::dp_stat_t                     stat_o,
  input  wire  [ctcgd_pkg::ScoreW-1:0]            score_i,
  input  wire                                     row_end_i,
  input  wire                                     seq_end_i,
  output logic                                    out_kind_o,
  output logic [ctcgd_pkg::IdxW-1:0]              out_index_o,
  output logic [ctcgd_pkg::ScoreW-1:0]            out_prob_o,
  output logic [ctcgd_pkg::ScoreW-1:0]            out_mean_o,
  output logic                                    out_accepted_o,
  output logic                                    out_last_o
);
  import ctcgd_pkg::*;

  localparam int unsigned RowLimit = (MaxClasses > 256) ? 256 : MaxClasses;
  localparam int unsigned CntW     = $clog2(RowLimit + 1);
  localparam int unsigned SumAddW  = SumW + 1;
  localparam logic [CntW-1:0] CntLimit = CntW'(RowLimit);

  logic [DictW-1:0]  dict_q;
  logic [ScoreW-1:0] min_conf_q;

  logic [ScoreW-1:0] best_q;
  logic [IdxW-1:0]   idx_q;
  logic [CntW-1:0]   cnt_q;
  logic [IdxW-1:0]   prev_q;
  logic              prev_vld_q;
  logic [SumW-1:0]   sum_q;
  logic [KeptW-1:0]  kept_q;

  logic [SumW-1:0]   quot_q;
  logic [KeptW-1:0]  rem_q;
  logic [KeptW-1:0]  den_q;

  logic              out_kind_q;
  logic [IdxW-1:0]   out_index_q;
  logic [ScoreW-1:0] out_prob_q;
  logic [ScoreW-1:0] out_mean_q;
  logic              out_acc_q;
  logic              out_last_q;

  logic              in_range;
  logic              upd;
  logic [ScoreW-1:0] best_new;
  logic [IdxW-1:0]   idx_new;
  logic              drop;
  logic [SumAddW-1:0] sum_add;
  logic [SumW-1:0]   sum_new;
  logic [KeptW-1:0]  kept_new;
  logic [KeptW:0]    rem_shift;
  logic              qbit;
  logic [ScoreW-1:0] mean_w;

  // Argmax over the row; first index wins on ties.
  always_comb begin
    in_range = cnt_q < CntLimit;
    upd      = in_range && ((cnt_q == '0) || (score_i > best_q));
    best_new = upd ? score_i : best_q;
    idx_new  = upd ? IdxW'(cnt_q) : idx_q;
    drop     = (idx_new == '0) || (prev_vld_q && (idx_new == prev_q));
    sum_add  = {1'b0, sum_q} + SumAddW'(best_new);
    sum_new  = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
    kept_new = (kept_q == KeptMax) ? kept_q : kept_q + 1'b1;
    stat_o.char_emit = row_end_i && !drop && ({1'b0, idx_new} < dict_q);
    stat_o.seq_done  = row_end_i && seq_end_i;
  end

  // Divider step and the capped mean.
  always_comb begin
    rem_shift = {rem_q, quot_q[SumW-1]};
    qbit      = rem_shift >= {1'b0, den_q};
    if (den_q == '0) begin
      mean_w = '0;
    end else if (|quot_q[SumW-1:ScoreW]) begin
      mean_w = '1;
    end else begin
      mean_w = quot_q[ScoreW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_q     <= '0;
      min_conf_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DICT_SIZE: dict_q     <= cfg_data_i[DictW-1:0];
        CFG_MIN_CONF:  min_conf_q <= cfg_data_i[ScoreW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q     <= '0;
      idx_q      <= '0;
      cnt_q      <= '0;
      prev_q     <= '0;
      prev_vld_q <= 1'b0;
      sum_q      <= '0;
      kept_q     <= '0;
    end else if (cmd_i.accept) begin
      if (row_end_i) begin
        best_q <= '0;
        idx_q  <= '0;
        cnt_q  <= '0;
        if (seq_end_i) begin
          prev_q     <= '0;
          prev_vld_q <= 1'b0;
          sum_q      <= '0;
          kept_q     <= '0;
        end else begin
          prev_q     <= idx_new;
          prev_vld_q <= 1'b1;
          if (!drop) begin
            sum_q  <= sum_new;
            kept_q <= kept_new;
          end
        end
      end else begin
        best_q <= best_new;
        idx_q  <= idx_new;
        if (in_range) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // Divider operands are captured with the final row folded in.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && stat_o.seq_done) begin
      quot_q <= drop ? sum_q : sum_new;
      den_q  <= drop ? kept_q : kept_new;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      quot_q <= {quot_q[SumW-2:0], qbit};
      rem_q  <= qbit ? KeptW'(rem_shift - {1'b0, den_q}) : rem_shift[KeptW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && stat_o.char_emit) begin
      out_kind_q  <= 1'b0;
      out_index_q <= idx_new;
      out_prob_q  <= best_new;
      out_mean_q  <= '0;
      out_acc_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (cmd_i.load_sum) begin
      out_kind_q  <= 1'b1;
      out_index_q <= '0;
      out_prob_q  <= '0;
      out_mean_q  <= mean_w;
      out_acc_q   <= mean_w >= min_conf_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_kind_o     = out_kind_q;
  assign out_index_o    = out_index_q;
  assign out_prob_o     = out_prob_q;
  assign out_mean_o     = out_mean_q;
  assign out_accepted_o = out_acc_q;
  assign out_last_o     = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/ctcgd_ctrl.sv -----
// Controller: accept gating, divider sequencing and output-register valid.
`default_nettype none

module ctcgd_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_valid_i,
  output logic                  s_ready_o,
  output logic                  m_valid_o,
  input  wire                   m_ready_i,
  input  wire ctcgd_pkg::dp_stat_t stat_i,
  output ctcgd_pkg::ctrl_cmd_t  cmd_o
);
  import ctcgd_pkg::*;

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

  ctrl_state_e        state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_vld_q, out_vld_d;
  logic               out_free;

  assign out_free  = !out_vld_q || m_ready_i;
  assign m_valid_o = out_vld_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: if (cmd_o.accept && stat_i.seq_done) state_d = ST_DIV;
      ST_DIV: if (cnt_q == '0) state_d = ST_SUM;
      ST_SUM: if (out_free) state_d = ST_RUN;
      default: state_d = ST_RUN;
    endcase
  end

  // Outputs and commands
  always_comb begin
    s_ready_o      = (state_q == ST_RUN) && out_free;
    cmd_o.accept   = s_valid_i && s_ready_o;
    cmd_o.div_step = state_q == ST_DIV;
    cmd_o.load_sum = (state_q == ST_SUM) && out_free;

    if (cmd_o.accept && stat_i.seq_done) begin
      cnt_d = DivLast;
    end else if ((state_q == ST_DIV) && (cnt_q != '0)) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end

    if ((cmd_o.accept && stat_i.char_emit) || cmd_o.load_sum) begin
      out_vld_d = 1'b1;
    end else if (m_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RUN;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  a_div_to_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (cnt_q == '0) |=> state_q == ST_SUM)
    else $error("divider did not hand over to summary");

  a_seq_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && stat_i.seq_done |=> (state_q == ST_DIV) && (cnt_q == DivLast))
    else $error("sequence end did not start a full division");

  a_sum_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_sum |=> out_vld_q && (state_q == ST_RUN))
    else $error("summary not presented");

endmodule

`default_nettype wire

// ----- tb/ctc_greedy_decoder_tb.sv -----
// Self-checking testbench of the CTC greedy decoder: directed and random score streams.
`default_nettype none

module ctc_greedy_decoder_tb;
  import ctcgd_pkg::*;

  localparam int unsigned MaxClasses = 256;
  // Argmax window of a row; later positions are ignored by the block.
  localparam int unsigned RowLimit   = (MaxClasses < 256) ? MaxClasses : 256;
  localparam int unsigned StallLimit = 3000;  // cycles without any transaction
  localparam int unsigned HoldCycles = 400;   // long receiver hold-off
  localparam int unsigned DrainWait  = 40;    // sequence-end divider plus handover
  localparam int unsigned MaxPrinted = 30;

  typedef struct {
    logic [ScoreW-1:0] score;
    logic              row_end;
    logic              seq_end;
  } score_item_t;

  typedef struct {
    logic              kind;   // 0 character, 1 summary
    logic [IdxW-1:0]   idx;
    logic [ScoreW-1:0] prob;
    logic [ScoreW-1:0] mean;
    logic              acc;
    logic              last;
  } decoded_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ScoreW-1:0]    s_axis_tdata  = '0;  // [15:0] class_score
  logic                 s_axis_tlast  = 1'b0; // row_end
  logic                 s_axis_tuser  = 1'b0; // seq_end

  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;  // [7:0] idx, [23:8] prob, [39:24] mean, [40] accepted
  logic                 m_axis_tlast;  // last
  logic                 m_axis_tuser;  // out_kind

  ctc_greedy_decoder #(
    .MAX_CLASSES(MaxClasses)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  score_item_t score_q[$];    // scores waiting to be sent
  decoded_t    decoded_q[$];  // results the decoder still owes
  int          err_count = 0;
  int          gen_count = 0;

  // Decoder copy: registers and per-sequence state.
  logic [DictW-1:0]  dict_lim = '0;
  logic [ScoreW-1:0] conf_min = '0;
  logic [ScoreW-1:0] top_score = '0;
  logic [IdxW-1:0]   top_index = '0;
  int unsigned       col_pos = 0;
  logic [IdxW-1:0]   last_class = '0;
  logic              have_last = 1'b0;
  logic [SumW-1:0]   kept_sum = '0;
  logic [KeptW-1:0]  kept_rows = '0;

  // Long hold-off request, raised once by the stimulus.
  bit hold_armed = 1'b0;

  task automatic flag_mismatch(input string what);
    err_count++;
    if (err_count <= MaxPrinted) $display("mismatch at %0t: %s", $time, what);
  endtask

  // Track the row argmax; on row end apply the CTC collapse rule and on
  // sequence end produce the mean summary.
  task automatic decode_score(input logic [ScoreW-1:0] sc, input logic re, input logic se);
    logic        drop;
    int unsigned acc_sum;
    int unsigned mean;
    decoded_t    r;
    if (col_pos < RowLimit) begin
      if (col_pos == 0 || sc > top_score) begin
        top_score = sc;
        top_index = col_pos[IdxW-1:0];
      end
      col_pos++;
    end
    if (!re) return;
    drop = (top_index == '0) || (have_last && top_index == last_class);
    if (!drop) begin
      if ({1'b0, top_index} < dict_lim) begin
        r = '{kind: 1'b0, idx: top_index, prob: top_score, mean: '0, acc: 1'b0, last: 1'b0};
        decoded_q = {decoded_q, r};
      end
      acc_sum = kept_sum + top_score;
      kept_sum = (acc_sum > SumMax) ? SumMax : acc_sum[SumW-1:0];
      if (kept_rows != KeptMax) kept_rows++;
    end
    last_class = top_index;
    have_last  = 1'b1;
    top_score  = '0;
    top_index  = '0;
    col_pos    = 0;
    if (se) begin
      mean = 0;
      if (kept_rows != 0) begin
        mean = kept_sum / kept_rows;
        if (mean > 16'hFFFF) mean = 16'hFFFF;
      end
      r = '{kind: 1'b1, idx: '0, prob: '0, mean: mean[ScoreW-1:0],
            acc: (mean >= conf_min), last: 1'b1};
      decoded_q = {decoded_q, r};
      last_class = '0;
      have_last  = 1'b0;
      kept_sum   = '0;
      kept_rows  = '0;
    end
  endtask

  task automatic check_result();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      flag_mismatch($sformatf("result with nothing expected, tdata %h", m_axis_tdata));
      return;
    end
    want = decoded_q.pop_front();
    if (m_axis_tuser !== want.kind)
      flag_mismatch($sformatf("out_kind %b, want %b", m_axis_tuser, want.kind));
    if (m_axis_tdata[7:0] !== want.idx)
      flag_mismatch($sformatf("char_index %0d, want %0d", m_axis_tdata[7:0], want.idx));
    if (m_axis_tdata[23:8] !== want.prob)
      flag_mismatch($sformatf("char_prob %h, want %h", m_axis_tdata[23:8], want.prob));
    if (m_axis_tdata[39:24] !== want.mean)
      flag_mismatch($sformatf("mean_score %h, want %h", m_axis_tdata[39:24], want.mean));
    if (m_axis_tdata[40] !== want.acc)
      flag_mismatch($sformatf("accepted %b, want %b", m_axis_tdata[40], want.acc));
    if (m_axis_tlast !== want.last)
      flag_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
  endtask

  // Score driver: bursts of random length separated by random gaps.
  score_item_t cur_item;
  int          burst_left = 0;
  int          gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_score(s_axis_tdata, s_axis_tlast, s_axis_tuser);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (score_q.size() > 0) begin
          cur_item = score_q.pop_front();
          s_axis_tdata  <= cur_item.score;
          s_axis_tlast  <= cur_item.row_end;
          s_axis_tuser  <= cur_item.seq_end;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall pattern.
  int rdy_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;
  int unsigned mon_cycle = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      mon_cycle++;
      if (hold_armed && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        rdy_mode  = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rdy_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (mon_cycle % 7) < 3;
        endcase
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("ctc_greedy_decoder_tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_score(input logic [ScoreW-1:0] sc, input logic re, input logic se);
    score_item_t it;
    it.score   = sc;
    it.row_end = re;
    it.seq_end = se;
    score_q = {score_q, it};
    gen_count++;
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [CfgDataW-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (r == CFG_DICT_SIZE) dict_lim = v[DictW-1:0];
    else conf_min = v;
  endtask

  // Wait until every score is sent and every result has come back.
  task automatic drain();
    while (score_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // One row with the winner at position win; later positions may tie it.
  // A nonzero w_force fixes the winning score.
  task automatic gen_row(input int len, input int win, input bit close_seq,
                         input logic [ScoreW-1:0] w_force);
    logic [ScoreW-1:0] w;
    logic [ScoreW-1:0] sc;
    w = (w_force != 0) ? w_force : 16'($urandom_range(1, 16'hFFFF));
    if (w_force == 0 && $urandom_range(0, 15) == 0) w = 16'hFFFF;
    for (int p = 0; p < len; p++) begin
      if (p == win) sc = w;
      else if (p < win) sc = 16'($urandom_range(0, w - 1));
      else sc = ($urandom_range(0, 3) == 0) ? w : 16'($urandom_range(0, w));
      if (p == len - 1) push_score(sc, 1'b1, close_seq);
      else push_score(sc, 1'b0, $urandom_range(0, 7) == 0);  // stray seq_end is ignored
    end
  endtask

  // Well-formed sequence: blanks, repeats and fresh winners mixed.
  task automatic gen_seq(input int steps, input int max_len);
    int len;
    int win;
    int prev;
    prev = -1;
    for (int t = 0; t < steps; t++) begin
      len = $urandom_range(1, max_len);
      case ($urandom_range(0, 3))
        0: win = 0;
        1: win = (prev >= 0 && prev < len) ? prev : $urandom_range(0, len - 1);
        default: win = $urandom_range(0, len - 1);
      endcase
      gen_row(len, win, t == steps - 1, '0);
      prev = win;
    end
  endtask

  // Random traffic: mostly sequences, some raw noise, always closed by a sequence.
  task automatic gen_traffic(input int n_items);
    int stop_at;
    int n;
    stop_at = gen_count + n_items;
    while (gen_count < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) push_score(16'($urandom), $urandom_range(0, 2) == 0,
                              1'($urandom_range(0, 1)));
      end
      gen_seq($urandom_range(1, 8), $urandom_range(2, 8));
    end
  endtask

  initial begin
    logic [ScoreW-1:0] w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full dictionary, threshold at one half.
    write_reg(CFG_DICT_SIZE, 16'd256);
    write_reg(CFG_MIN_CONF, 16'h8000);
    @(negedge clk_i);
    push_score(16'h0000, 1'b0, 1'b0);  // class 1 at full scale, kept
    push_score(16'hFFFF, 1'b1, 1'b0);
    push_score(16'd2, 1'b0, 1'b0);     // tie: first index, blank, dropped
    push_score(16'd2, 1'b1, 1'b0);
    push_score(16'd0, 1'b0, 1'b0);     // class 1 again after a blank row: kept
    push_score(16'd7, 1'b0, 1'b0);
    push_score(16'd7, 1'b1, 1'b0);
    push_score(16'd0, 1'b0, 1'b0);     // class 1 repeated: dropped
    push_score(16'd8, 1'b0, 1'b0);
    push_score(16'd1, 1'b1, 1'b0);
    push_score(16'd0, 1'b0, 1'b0);     // seq_end without row_end has no effect
    push_score(16'd0, 1'b0, 1'b1);
    push_score(16'h1234, 1'b1, 1'b1);
    push_score(16'hFFFF, 1'b1, 1'b1);  // one-class row, nothing kept: mean 0
    drain();

    // Empty dictionary, top threshold.
    write_reg(CFG_DICT_SIZE, 16'd0);
    write_reg(CFG_MIN_CONF, 16'hFFFF);
    @(negedge clk_i);
    push_score(16'd0, 1'b0, 1'b0);     // kept without a character, mean equals threshold
    push_score(16'hFFFF, 1'b1, 1'b1);
    push_score(16'd1, 1'b0, 1'b0);
    push_score(16'd2, 1'b0, 1'b0);
    push_score(16'd3, 1'b0, 1'b0);
    push_score(16'd4, 1'b1, 1'b1);
    drain();

    // Full dictionary, zero threshold: saturation and wide rows.
    write_reg(CFG_DICT_SIZE, 16'd256);
    write_reg(CFG_MIN_CONF, 16'h0000);
    @(negedge clk_i);
    gen_traffic(120);
    // Alternating winners at full scale: both the sum and the count saturate.
    for (int t = 0; t < 135; t++) gen_row(3, (t % 2) + 1, t == 134, 16'hFFFF);
    // Winner at the last counted position; larger scores past the window are ignored.
    w = 16'($urandom_range(1, 16'hFFFE));
    for (int p = 0; p < RowLimit + 4; p++) begin
      if (p < RowLimit - 1) push_score(16'($urandom_range(0, w - 1)), 1'b0, 1'b0);
      else if (p == RowLimit - 1) push_score(w, 1'b0, 1'b0);
      else push_score(16'hFFFF, p == RowLimit + 3, p == RowLimit + 3);
    end
    gen_traffic(120);
    drain();

    // Random dictionary and threshold; the receiver holds off once.
    write_reg(CFG_DICT_SIZE, 16'($urandom_range(1, 255)));
    write_reg(CFG_MIN_CONF, 16'($urandom));
    @(negedge clk_i);
    hold_armed = 1'b1;
    gen_traffic(280);
    drain();

    // Blank-only dictionary: no characters, summaries only.
    write_reg(CFG_DICT_SIZE, 16'd1);
    write_reg(CFG_MIN_CONF, 16'($urandom_range(0, 16'h3FFF)));
    @(negedge clk_i);
    gen_traffic(200);
    drain();

    // Small dictionary, threshold near the typical mean.
    write_reg(CFG_DICT_SIZE, 16'($urandom_range(2, 8)));
    write_reg(CFG_MIN_CONF, 16'($urandom_range(16'h4000, 16'hC000)));
    @(negedge clk_i);
    gen_traffic(230);
    drain();

    repeat (DrainWait) @(posedge clk_i);
    if (err_count == 0 && decoded_q.size() == 0) begin
      $display("ctc_greedy_decoder_tb OK");
    end else begin
      $display("ctc_greedy_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/ctcgd_pkg.sv
hdl/ctcgd_dpath.sv
hdl/ctcgd_ctrl.sv
hdl/ctc_greedy_decoder.sv
tb/ctc_greedy_decoder_tb.sv
